// File: hw/rtl/fgr_pkg.sv
package fgr_pkg;

  localparam int FONT_BYTES      = 4096;
  localparam int GLYPH_SLOTS     = 256;
  localparam int MAX_GLYPH_WIDTH = 32;
  localparam int MAX_ROWS        = 64;

  localparam int AW     = $clog2(FONT_BYTES);
  localparam int GIW    = $clog2(GLYPH_SLOTS);
  localparam int BASE_W = 17;
  localparam int QDEPTH = 4;

  localparam logic [5:0] MAX_WIDTH_C = 6'(MAX_GLYPH_WIDTH);
  localparam logic [7:0] ROW_MASK    = 8'(MAX_ROWS - 1);
  localparam logic [8:0] SLOTS_C     = 9'(GLYPH_SLOTS);

  localparam logic [15:0] FG_RESET    = 16'h0000;
  localparam logic [15:0] BG_RESET    = 16'hFFFF;
  localparam logic [8:0]  COUNT_RESET = 9'd128;

  typedef enum logic [1:0] {
    OP_FONT_WRITE   = 2'd0,
    OP_DESC_WRITE   = 2'd1,
    OP_RENDER       = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_FOREGROUND  = 2'd0,
    REG_BACKGROUND  = 2'd1,
    REG_BOLD        = 2'd2,
    REG_GLYPH_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_FONT,
    KIND_DESC,
    KIND_RENDER
  } kind_t;

  typedef struct packed {
    kind_t          kind;
    logic [7:0]     code;
    logic [5:0]     width;
    logic [11:0]    offset;
    logic [AW-1:0]  addr;
    logic [7:0]     data;
    logic [7:0]     row;
  } cmd_t;

  typedef struct packed {
    logic [15:0] foreground;
    logic [15:0] background;
    logic        bold;
    logic [8:0]  glyph_count;
  } cfg_t;

endpackage

// File: hw/rtl/font_glyph_row_renderer_core.sv
// proportional bitmap font row renderer
// in_ channel: one item per command; opcode 0 writes a font byte, 1 writes a
// glyph descriptor (width, byte offset), 2 renders one row of one glyph.
// out_ channel: one item per pixel, color in tdata, tlast on the row's last pixel.
// cfg_ channel: register writes (colors, bold, glyph count), always ready.
// accepted commands pass through a four-entry queue, so up to four commands are
// taken while a row is still being drawn; writes are applied as they are popped.
// a render pops the command, reads the descriptor, then per font byte fetches and
// loads it from the font memory and emits one pixel per cycle while out_tready
// stays high; bold adds a trailing pixel. after the queue pops, the first pixel
// goes through the descriptor, fetch, load and emit states, then the output register.
// render codes at or above the glyph count and opcode 3 are dropped at the input.
// a stalled receiver holds the output register and the pixel sequencer; the
// queue keeps accepting until full.
// reset clears the queue, the sequencer and the registers to their defaults;
// font and descriptor memories are not cleared and must be written first.
module font_glyph_row_renderer_core import fgr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode, glyph_code, glyph_width, glyph_offset, data_address, data_byte, row
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_color
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_pop, q_full, q_valid;
  cmd_t q_cmd, q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOREGROUND:  cfg_nxt.foreground  = cfg_data;
        REG_BACKGROUND:  cfg_nxt.background  = cfg_data;
        REG_BOLD:        cfg_nxt.bold        = cfg_data[0];
        REG_GLYPH_COUNT: cfg_nxt.glyph_count = cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.foreground  <= FG_RESET;
      cfg_r.background  <= BG_RESET;
      cfg_r.bold        <= 1'b0;
      cfg_r.glyph_count <= COUNT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fgr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  fgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  fgr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hw/rtl/fgr_ram.sv
module fgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/fgr_front.sv
module fgr_front import fgr_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [1:0]  opcode;
  logic [7:0]  code;
  logic [5:0]  width_in;
  logic [11:0] offset_in;
  logic [11:0] addr_in;
  logic [7:0]  byte_in;
  logic [5:0]  row_in;
  logic        take;

  assign opcode    = in_tdata[1:0];
  assign code      = in_tdata[9:2];
  assign width_in  = in_tdata[15:10];
  assign offset_in = in_tdata[27:16];
  assign addr_in   = in_tdata[39:28];
  assign byte_in   = in_tdata[47:40];
  assign row_in    = in_tdata[53:48];

  assign in_tready = !q_full;
  assign take      = in_tvalid && !q_full;

  always_comb begin
    q_cmd.kind   = KIND_FONT;
    q_cmd.code   = code;
    q_cmd.width  = (width_in > MAX_WIDTH_C) ? MAX_WIDTH_C : width_in;
    q_cmd.offset = offset_in;
    q_cmd.addr   = AW'(addr_in);
    q_cmd.data   = byte_in;
    q_cmd.row    = {2'b00, row_in} & ROW_MASK;
    q_push       = 1'b0;
    case (opcode_t'(opcode))
      OP_FONT_WRITE: begin
        q_cmd.kind = KIND_FONT;
        q_push     = take;
      end
      OP_DESC_WRITE: begin
        q_cmd.kind = KIND_DESC;
        q_push     = take && ({1'b0, code} < SLOTS_C);
      end
      OP_RENDER: begin
        q_cmd.kind = KIND_RENDER;
        q_push     = take && ({1'b0, code} < cfg.glyph_count) && ({1'b0, code} < SLOTS_C);
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/fgr_queue.sv
module fgr_queue import fgr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t          slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  assign full       = (count_r == (PW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance");

endmodule

// File: hw/rtl/fgr_back.sv
module fgr_back import fgr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DESC,
    ST_FETCH,
    ST_LOAD,
    ST_EMIT,
    ST_TAIL
  } state_t;

  state_t        state_r, state_nxt;
  logic [7:0]    row_r, row_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [5:0]    remain_r, remain_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          prev_r, prev_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_color_r, out_color_nxt;
  logic          out_last_r, out_last_nxt;

  logic           font_we, desc_we;
  logic [AW-1:0]  font_rd_addr;
  logic [7:0]     font_rd_data;
  logic [GIW-1:0] desc_rd_addr;
  logic [5:0]     wid_rd;
  logic [11:0]    off_rd;
  logic [2:0]     nbytes;
  logic [10:0]    row_prod;
  logic [BASE_W-1:0] base_sum;
  logic           emit_ok;

  fgr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
    .clk     (clk),
    .wr_en   (font_we),
    .wr_addr (q_head.addr),
    .wr_data (q_head.data),
    .rd_addr (font_rd_addr),
    .rd_data (font_rd_data)
  );

  fgr_ram #(.WIDTH(6), .DEPTH(GLYPH_SLOTS)) u_width (
    .clk     (clk),
    .wr_en   (desc_we),
    .wr_addr (q_head.code[GIW-1:0]),
    .wr_data (q_head.width),
    .rd_addr (desc_rd_addr),
    .rd_data (wid_rd)
  );

  fgr_ram #(.WIDTH(12), .DEPTH(GLYPH_SLOTS)) u_offset (
    .clk     (clk),
    .wr_en   (desc_we),
    .wr_addr (q_head.code[GIW-1:0]),
    .wr_data (q_head.offset),
    .rd_addr (desc_rd_addr),
    .rd_data (off_rd)
  );

  assign desc_rd_addr = q_head.code[GIW-1:0];
  assign font_rd_addr = addr_r;
  assign nbytes       = 3'(({1'b0, wid_rd} + 7'd7) >> 3);
  assign row_prod     = 11'(row_r) * 11'(nbytes);
  assign base_sum     = BASE_W'(off_rd) + BASE_W'(row_prod);
  assign emit_ok      = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    addr_nxt      = addr_r;
    remain_nxt    = remain_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    prev_nxt      = prev_r;
    out_valid_nxt = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    font_we       = 1'b0;
    desc_we       = 1'b0;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_head.kind)
            KIND_FONT: font_we = 1'b1;
            KIND_DESC: desc_we = 1'b1;
            KIND_RENDER: begin
              row_nxt   = q_head.row;
              state_nxt = ST_DESC;
            end
            default: ;
          endcase
        end
      end
      ST_DESC: begin
        remain_nxt = wid_rd;
        prev_nxt   = 1'b0;
        addr_nxt   = base_sum[AW-1:0];
        if (wid_rd == '0) begin
          state_nxt = cfg.bold ? ST_TAIL : ST_IDLE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        shift_nxt = font_rd_data;
        cnt_nxt   = (remain_r > 6'd8) ? 4'd8 : 4'(remain_r);
        addr_nxt  = addr_r + 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = (shift_r[0] || (cfg.bold && prev_r)) ? cfg.foreground
                                                               : cfg.background;
          out_last_nxt  = (remain_r == 6'd1) && !cfg.bold;
          prev_nxt      = shift_r[0];
          shift_nxt     = shift_r >> 1;
          cnt_nxt       = cnt_r - 1'b1;
          remain_nxt    = remain_r - 1'b1;
          if (remain_r == 6'd1) begin
            state_nxt = cfg.bold ? ST_TAIL : ST_IDLE;
          end else if (cnt_r == 4'd1) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_TAIL: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = prev_r ? cfg.foreground : cfg.background;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r       <= row_nxt;
    addr_r      <= addr_nxt;
    remain_r    <= remain_nxt;
    cnt_r       <= cnt_nxt;
    shift_r     <= shift_nxt;
    prev_r      <= prev_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_emit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r != '0) && (remain_r != '0) && (cnt_r <= 4'd8))
    else $error("pixel counters out of step");

  a_load_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> ($past(state_r) == ST_FETCH))
    else $error("font byte loaded without fetch");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE) && q_valid)
    else $error("queue popped while busy");

  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_TAIL) && emit_ok) |=> out_valid_r && out_last_r)
    else $error("trailing pixel not marked last");

endmodule

// File: sim/font_glyph_row_renderer_core_tb.sv
module font_glyph_row_renderer_core_tb import fgr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]  opcode;
    logic [7:0]  code;
    logic [5:0]  width;
    logic [11:0] offset;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [5:0]  row;
  } glyph_cmd_t;

  typedef struct {
    logic [15:0] color;
    logic        last;
  } pixel_t;

  typedef struct {
    logic [7:0] code;
    logic [5:0] row;
  } glyph_row_t;

  class glyph_row_tracker;
    logic [7:0]  font_mem [FONT_BYTES];
    bit          font_set [FONT_BYTES];
    logic [5:0]  width_tab [GLYPH_SLOTS];
    logic [11:0] offset_tab [GLYPH_SLOTS];
    bit          desc_set [GLYPH_SLOTS];
    logic [15:0] fg;
    logic [15:0] bg;
    logic        bold;
    logic [8:0]  count;
    pixel_t      expected_pixels [$];
    int          fails;

    function new();
      fg = FG_RESET;
      bg = BG_RESET;
      bold = 1'b0;
      count = COUNT_RESET;
      fails = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] v);
      case (idx)
        REG_FOREGROUND:  fg = v;
        REG_BACKGROUND:  bg = v;
        REG_BOLD:        bold = v[0];
        REG_GLYPH_COUNT: count = v[8:0];
        default: ;
      endcase
    endfunction

    // true when rendering this row touches only written entries
    function bit row_ready(logic [7:0] code, logic [5:0] row);
      int w;
      int nb;
      int base;
      if ({1'b0, code} >= count) return 1'b1;
      if (!desc_set[code]) return 1'b0;
      w = int'(width_tab[code]);
      nb = (w + 7) / 8;
      base = int'(offset_tab[code]) + int'(row % MAX_ROWS) * nb;
      for (int b = 0; b < nb; b++)
        if (!font_set[(base + b) % FONT_BYTES]) return 1'b0;
      return 1'b1;
    endfunction

    function void apply_cmd(glyph_cmd_t c);
      int w;
      int nb;
      int base;
      int total;
      logic px_bit;
      logic prev;
      pixel_t px;
      case (c.opcode)
        OP_FONT_WRITE: begin
          font_mem[int'(c.addr) % FONT_BYTES] = c.data;
          font_set[int'(c.addr) % FONT_BYTES] = 1'b1;
        end
        OP_DESC_WRITE: begin
          if (int'(c.code) < GLYPH_SLOTS) begin
            width_tab[c.code] = (c.width > MAX_WIDTH_C) ? MAX_WIDTH_C : c.width;
            offset_tab[c.code] = c.offset;
            desc_set[c.code] = 1'b1;
          end
        end
        OP_RENDER: begin
          if ({1'b0, c.code} < count && int'(c.code) < GLYPH_SLOTS) begin
            w = int'(width_tab[c.code]);
            nb = (w + 7) >> 3;
            base = int'(offset_tab[c.code]) + int'(c.row % MAX_ROWS) * nb;
            total = w + (bold ? 1 : 0);
            prev = 1'b0;
            for (int p = 0; p < w; p++) begin
              px_bit = font_mem[(base + p / 8) % FONT_BYTES][p % 8];
              px.color = (px_bit || (bold && prev)) ? fg : bg;
              px.last = (p + 1 == total);
              expected_pixels.push_back(px);
              prev = px_bit;
            end
            // bold adds a trailing column colored by the last bit
            if (bold) begin
              px.color = prev ? fg : bg;
              px.last = 1'b1;
              expected_pixels.push_back(px);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [15:0] color, logic last);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: pixel_color %h last_pixel %b", color, last);
        fails++;
        return;
      end
      want = expected_pixels.pop_front();
      if (color !== want.color) begin
        $error("pixel_color expected %h actual %h", want.color, color);
        fails++;
      end
      if (last !== want.last) begin
        $error("last_pixel expected %b actual %b", want.last, last);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  glyph_row_tracker sb = new();
  glyph_row_t  recent_rows [$];
  glyph_row_t  landmarks [$];
  int          items_sent = 0;
  int          src_idle_pct = 20;
  int          sink_idle_pct = 20;
  bit          quiet = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  font_glyph_row_renderer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
  end

  // pixel receiver: random stall bursts plus one long hold-off
  initial begin : pixel_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet && $urandom_range(99) < sink_idle_pct) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic glyph_cmd_t rand_cmd();
    glyph_cmd_t c;
    c.opcode = 2'($urandom);
    c.code = 8'($urandom);
    c.width = 6'($urandom);
    c.offset = 12'($urandom);
    c.addr = 12'($urandom);
    c.data = 8'($urandom);
    c.row = 6'($urandom);
    return c;
  endfunction

  function automatic glyph_cmd_t font_cmd(logic [11:0] addr, logic [7:0] data);
    glyph_cmd_t c;
    c = rand_cmd();
    c.opcode = OP_FONT_WRITE;
    c.addr = addr;
    c.data = data;
    return c;
  endfunction

  function automatic glyph_cmd_t desc_cmd(logic [7:0] code, logic [5:0] width,
                                          logic [11:0] offset);
    glyph_cmd_t c;
    c = rand_cmd();
    c.opcode = OP_DESC_WRITE;
    c.code = code;
    c.width = width;
    c.offset = offset;
    return c;
  endfunction

  function automatic glyph_cmd_t render_cmd(logic [7:0] code, logic [5:0] row);
    glyph_cmd_t c;
    c = rand_cmd();
    c.opcode = OP_RENDER;
    c.code = code;
    c.row = row;
    return c;
  endfunction

  function automatic glyph_row_t row_ref(logic [7:0] code, logic [5:0] row);
    glyph_row_t r;
    r.code = code;
    r.row = row;
    return r;
  endfunction

  task automatic send_cmd(input glyph_cmd_t c);
    if (!quiet && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, c.row, c.data, c.addr, c.offset, c.width, c.code, c.opcode};
    do @(posedge clk); while (!in_tready);
    sb.apply_cmd(c);
    if (c.opcode != OP_UNUSED && !(c.opcode == OP_RENDER && {1'b0, c.code} >= sb.count))
      items_sent++;
  endtask

  // wait for every pixel, then let queued writes retire
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
  endtask

  task automatic configure(input logic [15:0] fgc, input logic [15:0] bgc,
                           input logic boldc, input logic [8:0] cnt);
    drain();
    write_reg(REG_FOREGROUND, fgc);
    write_reg(REG_BACKGROUND, bgc);
    write_reg(REG_BOLD, {15'd0, boldc});
    write_reg(REG_GLYPH_COUNT, {7'd0, cnt});
    cfg_valid <= 1'b0;
  endtask

  // define a glyph, fill a few of its rows and draw them
  task automatic glyph_sequence();
    logic [7:0]  code;
    logic [5:0]  width;
    logic [11:0] offset;
    logic [5:0]  rows [3];
    logic [7:0]  data;
    int          sel;
    int          wsat;
    int          nb;
    int          nrows;
    if (sb.count != 0 && $urandom_range(7) != 0)
      code = 8'($urandom_range(0, int'(sb.count) - 1));
    else
      code = 8'($urandom);
    sel = $urandom_range(19);
    if (sel == 0) width = 6'd0;
    else if (sel == 1) width = 6'($urandom_range(33, 63));
    else if (sel == 2) width = 6'd32;
    else width = 6'($urandom_range(1, 32));
    wsat = (width > MAX_WIDTH_C) ? MAX_GLYPH_WIDTH : int'(width);
    nb = (wsat + 7) / 8;
    offset = 12'($urandom);
    nrows = $urandom_range(1, 3);
    send_cmd(desc_cmd(code, width, offset));
    for (int r = 0; r < nrows; r++) begin
      rows[r] = ($urandom_range(2) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      for (int b = 0; b < nb; b++) begin
        sel = $urandom_range(5);
        data = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
        send_cmd(font_cmd(12'((int'(offset) + int'(rows[r]) * nb + b) % FONT_BYTES), data));
      end
      recent_rows.push_back(row_ref(code, rows[r]));
    end
    for (int r = 0; r < nrows; r++) send_cmd(render_cmd(code, rows[r]));
    while (recent_rows.size() > 64) void'(recent_rows.pop_front());
  endtask

  task automatic random_phase(input int n_items);
    int start;
    int next_pick;
    glyph_cmd_t c;
    glyph_row_t gr;
    start = items_sent;
    next_pick = 0;
    while (items_sent - start < n_items) begin
      if (items_sent - start >= next_pick) begin
        src_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
        sink_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
        next_pick = next_pick + 40;
      end
      case ($urandom_range(9))
        0: begin
          c = rand_cmd();
          case ($urandom_range(3))
            0: c.opcode = OP_UNUSED;
            1: begin
              if (sb.count < 9'd256)
                c = render_cmd(8'($urandom_range(int'(sb.count), 255)), 6'($urandom));
              else
                c.opcode = OP_UNUSED;
            end
            2: c.opcode = OP_FONT_WRITE;
            default: c.opcode = OP_DESC_WRITE;
          endcase
          send_cmd(c);
        end
        1, 2: begin
          if (recent_rows.size() > 0) begin
            gr = recent_rows[$urandom_range(0, recent_rows.size() - 1)];
            if (sb.row_ready(gr.code, gr.row)) send_cmd(render_cmd(gr.code, gr.row));
          end
        end
        default: glyph_sequence();
      endcase
    end
  endtask

  task automatic revisit_landmarks();
    foreach (landmarks[i])
      if (sb.row_ready(landmarks[i].code, landmarks[i].row))
        send_cmd(render_cmd(landmarks[i].code, landmarks[i].row));
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FOREGROUND;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // glyph wrapping past the end of the store
    send_cmd(font_cmd(12'hFFF, 8'h81));
    send_cmd(font_cmd(12'h000, 8'h7E));
    send_cmd(desc_cmd(8'd0, 6'd16, 12'hFFF));
    send_cmd(render_cmd(8'd0, 6'd0));
    // over-wide glyph saturates, bottom row
    send_cmd(desc_cmd(8'd127, 6'd63, 12'd100));
    send_cmd(font_cmd(12'd352, 8'hFF));
    send_cmd(font_cmd(12'd353, 8'h00));
    send_cmd(font_cmd(12'd354, 8'h55));
    send_cmd(font_cmd(12'd355, 8'hAA));
    send_cmd(render_cmd(8'd127, 6'd63));
    // zero width
    send_cmd(desc_cmd(8'd5, 6'd0, 12'd0));
    send_cmd(render_cmd(8'd5, 6'd0));
    // bits running into a second partial byte
    send_cmd(desc_cmd(8'd3, 6'd9, 12'd2000));
    send_cmd(font_cmd(12'd2000, 8'h01));
    send_cmd(font_cmd(12'd2001, 8'h01));
    send_cmd(render_cmd(8'd3, 6'd0));
    // codes at or above the glyph count
    send_cmd(desc_cmd(8'd255, 6'd1, 12'hFFF));
    send_cmd(render_cmd(8'd255, 6'd0));
    send_cmd(render_cmd(8'd200, 6'd17));
    begin
      glyph_cmd_t c;
      c = rand_cmd();
      c.opcode = OP_UNUSED;
      send_cmd(c);
    end
    landmarks = '{row_ref(8'd0, 6'd0), row_ref(8'd127, 6'd63), row_ref(8'd5, 6'd0),
                  row_ref(8'd3, 6'd0), row_ref(8'd255, 6'd0)};
    random_phase(60);

    configure(16'hFFFF, 16'h0000, 1'b1, 9'd256);
    revisit_landmarks();
    random_phase(100);

    configure(16'($urandom), 16'($urandom), 1'b0, 9'd0);
    random_phase(20);

    configure(16'($urandom), 16'($urandom), 1'b1, 9'($urandom_range(1, 255)));
    long_hold_req = 1'b1;
    revisit_landmarks();
    random_phase(120);

    configure(16'h0000, 16'hFFFF, 1'b0, 9'd256);
    quiet = 1'b1;
    revisit_landmarks();
    random_phase(100);

    drain();
    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fgr_pkg.sv
hw/rtl/fgr_ram.sv
hw/rtl/fgr_front.sv
hw/rtl/fgr_queue.sv
hw/rtl/fgr_back.sv
hw/rtl/font_glyph_row_renderer_core.sv
sim/font_glyph_row_renderer_core_tb.sv
